// ----- sv/mi3_pkg.sv -----
`timescale 1ns / 1ps
package mi3_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_ELEM = 9;
   localparam int EPS_WIDTH = 16;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd1;
   localparam int QUEUE_DEPTH = 4;
endpackage

// ----- sv/mi3_ifs.sv -----
`timescale 1ns / 1ps
interface mi3_req_if #(parameter int DW = 32);
   logic valid;
   logic ready;
   logic signed [DW-1:0] in_c0_r0;
   logic signed [DW-1:0] in_c0_r1;
   logic signed [DW-1:0] in_c0_r2;
   logic signed [DW-1:0] in_c1_r0;
   logic signed [DW-1:0] in_c1_r1;
   logic signed [DW-1:0] in_c1_r2;
   logic signed [DW-1:0] in_c2_r0;
   logic signed [DW-1:0] in_c2_r1;
   logic signed [DW-1:0] in_c2_r2;
   modport source (output valid, output in_c0_r0, output in_c0_r1, output in_c0_r2,
      output in_c1_r0, output in_c1_r1, output in_c1_r2, output in_c2_r0,
      output in_c2_r1, output in_c2_r2, input ready);
   modport sink (input valid, input in_c0_r0, input in_c0_r1, input in_c0_r2,
      input in_c1_r0, input in_c1_r1, input in_c1_r2, input in_c2_r0,
      input in_c2_r1, input in_c2_r2, output ready);
endinterface

interface mi3_rsp_if #(parameter int DW = 32);
   logic valid;
   logic ready;
   logic signed [DW-1:0] out_c0_r0;
   logic signed [DW-1:0] out_c0_r1;
   logic signed [DW-1:0] out_c0_r2;
   logic signed [DW-1:0] out_c1_r0;
   logic signed [DW-1:0] out_c1_r1;
   logic signed [DW-1:0] out_c1_r2;
   logic signed [DW-1:0] out_c2_r0;
   logic signed [DW-1:0] out_c2_r1;
   logic signed [DW-1:0] out_c2_r2;
   logic signed [DW-1:0] det_value;
   logic singular;
   modport source (output valid, output out_c0_r0, output out_c0_r1, output out_c0_r2,
      output out_c1_r0, output out_c1_r1, output out_c1_r2, output out_c2_r0,
      output out_c2_r1, output out_c2_r2, output det_value, output singular,
      input ready);
   modport sink (input valid, input out_c0_r0, input out_c0_r1, input out_c0_r2,
      input out_c1_r0, input out_c1_r1, input out_c1_r2, input out_c2_r0,
      input out_c2_r1, input out_c2_r2, input det_value, input singular,
      output ready);
endinterface

interface mi3_data_if #(parameter int WIDTH = 1);
   logic valid;
   logic ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- sv/mi3_front.sv -----
`timescale 1ns / 1ps
module mi3_front #(
   parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic [mi3_pkg::EPS_WIDTH-1:0] csr_eps,
   mi3_req_if.sink req_ch,
   mi3_data_if.source push_ch
);
   import mi3_pkg::*;

   localparam int DW = DATA_WIDTH;
   typedef logic signed [DW-1:0] elem_type;
   localparam elem_type ELEM_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam elem_type ELEM_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [2*DW-1:0] MAX_P = {{(DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [2*DW-1:0] MIN_P = {{(DW+1){1'b1}}, {(DW-1){1'b0}}};
   localparam logic signed [DW:0] MAX_1 = {2'b00, {(DW-1){1'b1}}};
   localparam logic signed [DW:0] MIN_1 = {2'b11, {(DW-1){1'b0}}};
   localparam logic signed [DW+1:0] MAX_2 = {3'b000, {(DW-1){1'b1}}};
   localparam logic signed [DW+1:0] MIN_2 = {3'b111, {(DW-1){1'b0}}};

   // Operand pairs of each cofactor: first product minus second product.
   localparam logic [3:0] COF_SEL [NUM_ELEM][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}};

   function automatic elem_type mulq(input elem_type a, input elem_type b);
      logic signed [2*DW-1:0] p;
      logic signed [2*DW-1:0] s;
      p = a * b;
      s = p >>> FRAC_BITS;
      if (s > MAX_P) begin
         mulq = ELEM_MAX;
      end else if (s < MIN_P) begin
         mulq = ELEM_MIN;
      end else begin
         mulq = s[DW-1:0];
      end
   endfunction

   function automatic elem_type sat_1(input logic signed [DW:0] x);
      if (x > MAX_1) begin
         sat_1 = ELEM_MAX;
      end else if (x < MIN_1) begin
         sat_1 = ELEM_MIN;
      end else begin
         sat_1 = x[DW-1:0];
      end
   endfunction

   function automatic elem_type sat_2(input logic signed [DW+1:0] x);
      if (x > MAX_2) begin
         sat_2 = ELEM_MAX;
      end else if (x < MIN_2) begin
         sat_2 = ELEM_MIN;
      end else begin
         sat_2 = x[DW-1:0];
      end
   endfunction

   elem_type req_v [NUM_ELEM];
   elem_type s0_v_ff [NUM_ELEM];
   elem_type s1_p_ff [2*NUM_ELEM];
   elem_type s1_p_in [2*NUM_ELEM];
   elem_type s1_vc_ff [3];
   elem_type s2_adj_ff [NUM_ELEM];
   elem_type s2_adj_in [NUM_ELEM];
   elem_type s2_vc_ff [3];
   elem_type s3_dp_ff [3];
   elem_type s3_dp_in [3];
   elem_type s3_adj_ff [NUM_ELEM];
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [DW+1:0] det_sum;
   elem_type det;
   logic [DW-1:0] det_mag;
   logic sing;
   logic advance;

   assign req_v[0] = req_ch.in_c0_r0;
   assign req_v[1] = req_ch.in_c0_r1;
   assign req_v[2] = req_ch.in_c0_r2;
   assign req_v[3] = req_ch.in_c1_r0;
   assign req_v[4] = req_ch.in_c1_r1;
   assign req_v[5] = req_ch.in_c1_r2;
   assign req_v[6] = req_ch.in_c2_r0;
   assign req_v[7] = req_ch.in_c2_r1;
   assign req_v[8] = req_ch.in_c2_r2;

   // The whole front moves together; it holds only when its last stage cannot hand off.
   assign advance = !s3_valid_ff || push_ch.ready;
   assign req_ch.ready = advance;

   always_comb begin
      for (int i = 0; i < NUM_ELEM; i++) begin
         s1_p_in[2*i]   = mulq(s0_v_ff[COF_SEL[i][0]], s0_v_ff[COF_SEL[i][1]]);
         s1_p_in[2*i+1] = mulq(s0_v_ff[COF_SEL[i][2]], s0_v_ff[COF_SEL[i][3]]);
         s2_adj_in[i] = sat_1({s1_p_ff[2*i][DW-1], s1_p_ff[2*i]}
                            - {s1_p_ff[2*i+1][DW-1], s1_p_ff[2*i+1]});
      end
      for (int k = 0; k < 3; k++) begin
         s3_dp_in[k] = mulq(s2_vc_ff[k], s2_adj_ff[k]);
      end
      det_sum = {{2{s3_dp_ff[0][DW-1]}}, s3_dp_ff[0]}
              + {{2{s3_dp_ff[1][DW-1]}}, s3_dp_ff[1]}
              + {{2{s3_dp_ff[2][DW-1]}}, s3_dp_ff[2]};
      det = sat_2(det_sum);
      det_mag = det[DW-1] ? (~det + 1'b1) : det;
      sing = det_mag <= DW'(csr_eps);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_ch.valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_v_ff <= req_v;
         s1_p_ff <= s1_p_in;
         s1_vc_ff[0] <= s0_v_ff[0];
         s1_vc_ff[1] <= s0_v_ff[3];
         s1_vc_ff[2] <= s0_v_ff[6];
         s2_adj_ff <= s2_adj_in;
         s2_vc_ff <= s1_vc_ff;
         s3_dp_ff <= s3_dp_in;
         s3_adj_ff <= s2_adj_ff;
      end
   end

   always_comb begin
      push_ch.data = '0;
      for (int i = 0; i < NUM_ELEM; i++) begin
         push_ch.data[i*DW +: DW] = s3_adj_ff[i];
      end
      push_ch.data[NUM_ELEM*DW +: DW] = det;
      push_ch.data[(NUM_ELEM+1)*DW] = sing;
   end
   assign push_ch.valid = s3_valid_ff;
endmodule

// ----- sv/mi3_queue.sv -----
`timescale 1ns / 1ps
module mi3_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = mi3_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   mi3_data_if.sink push_ch,
   mi3_data_if.source pop_ch
);
   import mi3_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ch.ready = count_ff != CW'(DEPTH);
   assign pop_ch.valid = count_ff != '0;
   assign pop_ch.data = mem_ff[rd_ptr_ff];
   assign push = push_ch.valid && push_ch.ready;
   assign pop = pop_ch.valid && pop_ch.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_ch.data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a write");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree while empty");
endmodule

// ----- sv/mi3_back.sv -----
`timescale 1ns / 1ps
module mi3_back #(
   parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   mi3_data_if.sink pop_ch,
   mi3_rsp_if.source rsp_ch
);
   import mi3_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int PW = (NUM_ELEM + 1) * DW + 1;
   localparam int QW = 2 * FRAC_BITS + 1;
   localparam int CW = ((QW > DW) ? QW : DW) + 1;
   typedef logic signed [DW-1:0] elem_type;
   localparam elem_type ELEM_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam elem_type ELEM_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [2*DW-1:0] MAX_P = {{(DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [2*DW-1:0] MIN_P = {{(DW+1){1'b1}}, {(DW-1){1'b0}}};
   localparam logic [CW-1:0] POS_LIM = CW'({(DW-1){1'b1}});
   localparam logic [CW-1:0] NEG_LIM = POS_LIM + CW'(1);

   function automatic elem_type sat_prod(input logic signed [2*DW-1:0] p);
      logic signed [2*DW-1:0] s;
      s = p >>> FRAC_BITS;
      if (s > MAX_P) begin
         sat_prod = ELEM_MAX;
      end else if (s < MIN_P) begin
         sat_prod = ELEM_MIN;
      end else begin
         sat_prod = s[DW-1:0];
      end
   endfunction

   logic advance;
   logic [DW-1:0] in_det_mag;

   logic dv_valid_ff [QW];
   logic [DW-1:0] dv_rem_ff [QW];
   logic [QW-1:0] dv_q_ff [QW];
   logic [DW-1:0] dv_d_ff [QW];
   logic [PW-1:0] dv_pl_ff [QW];

   logic r_valid_ff;
   elem_type r_recip_ff, r_recip_in;
   logic [PW-1:0] r_pl_ff;
   logic [CW-1:0] q_ext;

   logic p_valid_ff;
   logic signed [2*DW-1:0] p_prod_ff [NUM_ELEM];
   elem_type p_det_ff;
   logic p_sing_ff;

   logic o_valid_ff;
   elem_type o_elem_ff [NUM_ELEM];
   elem_type o_elem_in [NUM_ELEM];
   elem_type o_det_ff;
   logic o_sing_ff;

   assign advance = !o_valid_ff || rsp_ch.ready;
   assign pop_ch.ready = advance;
   assign in_det_mag = pop_ch.data[(NUM_ELEM+1)*DW-1]
                     ? (~pop_ch.data[NUM_ELEM*DW +: DW] + 1'b1)
                     : pop_ch.data[NUM_ELEM*DW +: DW];

   // Restoring division of 2^(2*FRAC_BITS) by |det|, one quotient bit per stage.
   for (genvar k = 0; k < QW; k++) begin : g_div
      logic src_valid;
      logic [DW-1:0] src_rem;
      logic [QW-1:0] src_q;
      logic [DW-1:0] src_d;
      logic [PW-1:0] src_pl;
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic ge;

      if (k == 0) begin : g_first
         assign src_valid = pop_ch.valid;
         assign src_rem = '0;
         assign src_q = '0;
         assign src_d = in_det_mag;
         assign src_pl = pop_ch.data;
      end else begin : g_next
         assign src_valid = dv_valid_ff[k-1];
         assign src_rem = dv_rem_ff[k-1];
         assign src_q = dv_q_ff[k-1];
         assign src_d = dv_d_ff[k-1];
         assign src_pl = dv_pl_ff[k-1];
      end

      assign trial = {src_rem, 1'(k == 0)};
      assign ge = trial >= {1'b0, src_d};
      assign diff = trial - {1'b0, src_d};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            dv_valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_rem_ff[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            dv_q_ff[k] <= {src_q[QW-2:0], ge};
            dv_d_ff[k] <= src_d;
            dv_pl_ff[k] <= src_pl;
         end
      end
   end

   always_comb begin
      q_ext = CW'(dv_q_ff[QW-1]);
      if (dv_pl_ff[QW-1][(NUM_ELEM+1)*DW-1]) begin
         r_recip_in = (q_ext > NEG_LIM) ? ELEM_MIN : (~q_ext[DW-1:0] + 1'b1);
      end else begin
         r_recip_in = (q_ext > POS_LIM) ? ELEM_MAX : q_ext[DW-1:0];
      end
      for (int i = 0; i < NUM_ELEM; i++) begin
         o_elem_in[i] = p_sing_ff ? '0 : sat_prod(p_prod_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         r_valid_ff <= dv_valid_ff[QW-1];
         p_valid_ff <= r_valid_ff;
         o_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_recip_ff <= r_recip_in;
         r_pl_ff <= dv_pl_ff[QW-1];
         for (int i = 0; i < NUM_ELEM; i++) begin
            p_prod_ff[i] <= $signed(r_pl_ff[i*DW +: DW]) * r_recip_ff;
         end
         p_det_ff <= r_pl_ff[NUM_ELEM*DW +: DW];
         p_sing_ff <= r_pl_ff[(NUM_ELEM+1)*DW];
         o_elem_ff <= o_elem_in;
         o_det_ff <= p_det_ff;
         o_sing_ff <= p_sing_ff;
      end
   end

   assign rsp_ch.valid = o_valid_ff;
   assign rsp_ch.out_c0_r0 = o_elem_ff[0];
   assign rsp_ch.out_c0_r1 = o_elem_ff[1];
   assign rsp_ch.out_c0_r2 = o_elem_ff[2];
   assign rsp_ch.out_c1_r0 = o_elem_ff[3];
   assign rsp_ch.out_c1_r1 = o_elem_ff[4];
   assign rsp_ch.out_c1_r2 = o_elem_ff[5];
   assign rsp_ch.out_c2_r0 = o_elem_ff[6];
   assign rsp_ch.out_c2_r1 = o_elem_ff[7];
   assign rsp_ch.out_c2_r2 = o_elem_ff[8];
   assign rsp_ch.det_value = o_det_ff;
   assign rsp_ch.singular = o_sing_ff;
endmodule

// ----- sv/matrix3x3_inverse_top.sv -----
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate, signed fixed point (Q16.16 by default).
// The req channel carries one matrix per transfer, nine elements column by
// column; the rsp channel returns the nine inverse elements in the same order,
// the saturated determinant and a singular flag. When the determinant's
// magnitude is at or below the epsilon register, the inverse elements are zero.
// The epsilon register is written through csr_wr_en / csr_wr_data; the user
// must write it only while the block is idle, as the block itself does not
// enforce this. Reset sets it to one raw unit. From a request transfer to the
// response being offered, a matrix passes the input register, the cofactor
// product, adjugate and determinant product registers, the queue, one divider
// stage per quotient bit, then reciprocal saturation, the final multiply and
// the output register. One matrix is taken per cycle as long as responses are
// taken.
// When the receiver stalls, the back end holds and the four-entry queue fills
// before req ready falls. Reset empties all stages and the queue.
module matrix3x3_inverse_top #(
   parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   mi3_req_if.sink req_ch,
   mi3_rsp_if.source rsp_ch,
   input  logic csr_wr_en,
   input  logic [mi3_pkg::EPS_WIDTH-1:0] csr_wr_data
);
   import mi3_pkg::*;

   localparam int PW = (NUM_ELEM + 1) * DATA_WIDTH + 1;

   logic [EPS_WIDTH-1:0] eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_wr_en) begin
         eps_ff <= csr_wr_data;
      end
   end

   mi3_data_if #(.WIDTH(PW)) push_ch ();
   mi3_data_if #(.WIDTH(PW)) pop_ch ();

   mi3_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .csr_eps (eps_ff),
      .req_ch  (req_ch),
      .push_ch (push_ch)
   );

   mi3_queue #(.WIDTH(PW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_ch (push_ch),
      .pop_ch  (pop_ch)
   );

   mi3_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock  (clock),
      .reset  (reset),
      .pop_ch (pop_ch),
      .rsp_ch (rsp_ch)
   );
endmodule
